FILE: rtl/md5sh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hash: shared package
// Types, the microcode program and the MD5 round constants.
// ----------------------------------------------------------------------------
package md5sh_pkg;

	typedef logic [4:0] step_t;

	// Datapath operations selected by the current control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_CMP_INIT,
		OP_ROUND,
		OP_CMP_FINAL,
		OP_CMP_FIN_SPILL,
		OP_PAD80,
		OP_ZERO,
		OP_LEN_LO,
		OP_LEN_HI,
		OP_EMIT
	} op_t;

	// Jump conditions; a true condition loads the target, otherwise the
	// step counter advances by one.
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_IDLE_STAY,
		C_NOT_FULL,
		C_NOT_LAST,
		C_ZDONE,
		C_NOT_SPILL,
		C_NOT_RDONE,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// Status returned from the datapath to the sequencer.
	typedef struct packed {
		logic idle_stay;
		logic full_q;
		logic last_q;
		logic zdone;
		logic spill_q;
		logic rdone;
		logic out_full;
	} flags_t;

	localparam step_t STEP_IDLE      = 5'd0;
	localparam step_t STEP_TEST_FULL = 5'd1;
	localparam step_t STEP_CMP_A     = 5'd2;
	localparam step_t STEP_RND_A     = 5'd3;
	localparam step_t STEP_FIN_A     = 5'd4;
	localparam step_t STEP_TEST_LAST = 5'd5;
	localparam step_t STEP_PAD       = 5'd6;
	localparam step_t STEP_ZTEST     = 5'd7;
	localparam step_t STEP_ZERO      = 5'd8;
	localparam step_t STEP_SPILL     = 5'd9;
	localparam step_t STEP_CMP_B     = 5'd10;
	localparam step_t STEP_RND_B     = 5'd11;
	localparam step_t STEP_FIN_B     = 5'd12;
	localparam step_t STEP_LEN_LO    = 5'd13;
	localparam step_t STEP_LEN_HI    = 5'd14;
	localparam step_t STEP_CMP_C     = 5'd15;
	localparam step_t STEP_RND_C     = 5'd16;
	localparam step_t STEP_WAIT      = 5'd17;
	localparam step_t STEP_EMIT      = 5'd18;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] SPILL_POS  = 6'd56;
	localparam logic [3:0] LEN_LO_IDX = 4'd14;
	localparam logic [3:0] LEN_HI_IDX = 4'd15;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// Message word used by a round.
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] i;
		logic [3:0] g;
		i = rnd[3:0];
		case (rnd[5:4])
			2'd0:    g = i;
			2'd1:    g = 4'(i * 4'd5 + 4'd1);
			2'd2:    g = 4'(i * 4'd3 + 4'd5);
			default: g = 4'(i * 4'd7);
		endcase
		return g;
	endfunction

	// The control program.
	function automatic uword_t ucode(input step_t step);
		uword_t uw;
		unique case (step)
			STEP_IDLE:      uw = '{OP_ACCEPT,        C_IDLE_STAY, STEP_IDLE};
			STEP_TEST_FULL: uw = '{OP_NOP,           C_NOT_FULL,  STEP_PAD};
			STEP_CMP_A:     uw = '{OP_CMP_INIT,      C_NEXT,      STEP_IDLE};
			STEP_RND_A:     uw = '{OP_ROUND,         C_NOT_RDONE, STEP_RND_A};
			STEP_FIN_A:     uw = '{OP_CMP_FINAL,     C_NEXT,      STEP_IDLE};
			STEP_TEST_LAST: uw = '{OP_NOP,           C_NOT_LAST,  STEP_IDLE};
			STEP_PAD:       uw = '{OP_PAD80,         C_NEXT,      STEP_IDLE};
			STEP_ZTEST:     uw = '{OP_NOP,           C_ZDONE,     STEP_SPILL};
			STEP_ZERO:      uw = '{OP_ZERO,          C_ALWAYS,    STEP_ZTEST};
			STEP_SPILL:     uw = '{OP_NOP,           C_NOT_SPILL, STEP_LEN_LO};
			STEP_CMP_B:     uw = '{OP_CMP_INIT,      C_NEXT,      STEP_IDLE};
			STEP_RND_B:     uw = '{OP_ROUND,         C_NOT_RDONE, STEP_RND_B};
			STEP_FIN_B:     uw = '{OP_CMP_FIN_SPILL, C_ALWAYS,    STEP_ZTEST};
			STEP_LEN_LO:    uw = '{OP_LEN_LO,        C_NEXT,      STEP_IDLE};
			STEP_LEN_HI:    uw = '{OP_LEN_HI,        C_NEXT,      STEP_IDLE};
			STEP_CMP_C:     uw = '{OP_CMP_INIT,      C_NEXT,      STEP_IDLE};
			STEP_RND_C:     uw = '{OP_ROUND,         C_NOT_RDONE, STEP_RND_C};
			STEP_WAIT:      uw = '{OP_NOP,           C_OUT_FULL,  STEP_WAIT};
			STEP_EMIT:      uw = '{OP_EMIT,          C_ALWAYS,    STEP_IDLE};
			default:        uw = '{OP_NOP,           C_ALWAYS,    STEP_IDLE};
		endcase
		return uw;
	endfunction

endpackage

FILE: rtl/md5sh_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hash: channel interfaces
// Valid/ready channels for message bytes and for digests.
// ----------------------------------------------------------------------------
interface md5sh_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, data_byte, has_byte, last, input ready);
	modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface md5sh_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;

	modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
		input ready);
	modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
		output ready);
endinterface

FILE: rtl/md5sh_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hash: microcode sequencer
// Step counter, program ROM and conditional jump logic.
// ----------------------------------------------------------------------------
module md5sh_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  md5sh_pkg::flags_t flags,
	output md5sh_pkg::op_t    op
);

	md5sh_pkg::step_t  step_q;
	md5sh_pkg::step_t  step_d;
	md5sh_pkg::uword_t uw;
	logic              jump;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= md5sh_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		uw = md5sh_pkg::ucode(step_q);
		op = uw.op;
		unique case (uw.cond)
			md5sh_pkg::C_NEXT:      jump = 1'b0;
			md5sh_pkg::C_ALWAYS:    jump = 1'b1;
			md5sh_pkg::C_IDLE_STAY: jump = flags.idle_stay;
			md5sh_pkg::C_NOT_FULL:  jump = !flags.full_q;
			md5sh_pkg::C_NOT_LAST:  jump = !flags.last_q;
			md5sh_pkg::C_ZDONE:     jump = flags.zdone;
			md5sh_pkg::C_NOT_SPILL: jump = !flags.spill_q;
			md5sh_pkg::C_NOT_RDONE: jump = !flags.rdone;
			md5sh_pkg::C_OUT_FULL:  jump = flags.out_full;
			default:                jump = 1'b0;
		endcase
		step_d = jump ? uw.target : step_q + 5'd1;
	end

endmodule

FILE: rtl/md5sh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hash: datapath
// Block buffer, byte counter, chaining words, round unit and digest register.
// ----------------------------------------------------------------------------
module md5sh_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  md5sh_pkg::op_t    op,
	output md5sh_pkg::flags_t flags,
	md5sh_msg_if.sink         msg,
	md5sh_dig_if.source       digest
);

	logic [31:0] mem [16];
	logic [31:0] rdata_q;
	logic [60:0] cnt_q;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic [4:0]  wcnt_q;
	logic        full_q, last_q, spill_q;
	logic        out_valid_q;
	logic [31:0] out_q [4];

	logic        fire, take_byte, full_now;
	logic [5:0]  pos;
	logic [1:0]  lane;
	logic [3:0]  word;
	logic        we;
	logic [3:0]  waddr, wbe, raddr;
	logic [31:0] wdata;
	logic [31:0] f, sum, rot;
	logic [4:0]  sh;

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {v, v} << n;
		return dbl[63:32];
	endfunction

	assign msg.ready = (op == md5sh_pkg::OP_ACCEPT);
	assign fire      = msg.valid & msg.ready;
	assign take_byte = fire & msg.has_byte;
	assign pos       = cnt_q[5:0];
	assign lane      = pos[1:0];
	assign word      = pos[5:2];
	assign full_now  = take_byte & (&pos);

	assign flags.idle_stay = !fire | (!full_now & !msg.last);
	assign flags.full_q    = full_q;
	assign flags.last_q    = last_q;
	assign flags.zdone     = wcnt_q[4];
	assign flags.spill_q   = spill_q;
	assign flags.rdone     = &rnd_q;
	assign flags.out_full  = out_valid_q & !digest.ready;

	// A byte written into a lane clears the lanes above it.
	always_comb begin
		we    = 1'b0;
		waddr = word;
		wbe   = 4'hf;
		wdata = '0;
		unique case (op)
			md5sh_pkg::OP_ACCEPT: begin
				we    = take_byte;
				wbe   = 4'hf << lane;
				wdata = 32'(msg.data_byte) << {lane, 3'b000};
			end
			md5sh_pkg::OP_PAD80: begin
				we    = 1'b1;
				wbe   = 4'hf << lane;
				wdata = 32'(md5sh_pkg::PAD_BYTE) << {lane, 3'b000};
			end
			md5sh_pkg::OP_ZERO: begin
				we    = 1'b1;
				waddr = wcnt_q[3:0];
			end
			md5sh_pkg::OP_LEN_LO: begin
				we    = 1'b1;
				waddr = md5sh_pkg::LEN_LO_IDX;
				wdata = {cnt_q[28:0], 3'b000};
			end
			md5sh_pkg::OP_LEN_HI: begin
				we    = 1'b1;
				waddr = md5sh_pkg::LEN_HI_IDX;
				wdata = cnt_q[60:29];
			end
			default: ;
		endcase
	end

	// The read runs one round ahead so the word is registered in time.
	assign raddr = md5sh_pkg::msg_index((op == md5sh_pkg::OP_ROUND) ? rnd_q + 6'd1 : rnd_q);

	always_ff @(posedge clk) begin
		if (we) begin
			for (int l = 0; l < 4; l++) begin
				if (wbe[l]) begin
					mem[waddr][8*l +: 8] <= wdata[8*l +: 8];
				end
			end
		end
		rdata_q <= mem[raddr];
	end

	always_comb begin
		case (rnd_q[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sh  = md5sh_pkg::ROT_S[{rnd_q[5:4], rnd_q[1:0]}];
		sum = a_q + f + md5sh_pkg::ROUND_K[rnd_q] + rdata_q;
		rot = rotl(sum, sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			chain_q[0]  <= md5sh_pkg::IV0;
			chain_q[1]  <= md5sh_pkg::IV1;
			chain_q[2]  <= md5sh_pkg::IV2;
			chain_q[3]  <= md5sh_pkg::IV3;
			rnd_q       <= '0;
			wcnt_q      <= '0;
			full_q      <= 1'b0;
			last_q      <= 1'b0;
			spill_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (op)
				md5sh_pkg::OP_ACCEPT: begin
					if (fire) begin
						if (msg.has_byte) begin
							cnt_q <= cnt_q + 61'd1;
						end
						full_q <= full_now;
						last_q <= msg.last;
					end
				end
				md5sh_pkg::OP_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
				end
				md5sh_pkg::OP_CMP_FINAL: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
				end
				md5sh_pkg::OP_CMP_FIN_SPILL: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					wcnt_q     <= '0;
					spill_q    <= 1'b0;
				end
				md5sh_pkg::OP_PAD80: begin
					wcnt_q  <= {1'b0, word} + 5'd1;
					spill_q <= (pos >= md5sh_pkg::SPILL_POS);
				end
				md5sh_pkg::OP_ZERO: begin
					wcnt_q <= wcnt_q + 5'd1;
				end
				md5sh_pkg::OP_EMIT: begin
					chain_q[0] <= md5sh_pkg::IV0;
					chain_q[1] <= md5sh_pkg::IV1;
					chain_q[2] <= md5sh_pkg::IV2;
					chain_q[3] <= md5sh_pkg::IV3;
					cnt_q      <= '0;
				end
				default: ;
			endcase
			if (op == md5sh_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op == md5sh_pkg::OP_CMP_INIT) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (op == md5sh_pkg::OP_ROUND) begin
			a_q <= d_q;
			b_q <= b_q + rot;
			c_q <= b_q;
			d_q <= c_q;
		end
		if (op == md5sh_pkg::OP_EMIT) begin
			out_q[0] <= chain_q[0] + a_q;
			out_q[1] <= chain_q[1] + b_q;
			out_q[2] <= chain_q[2] + c_q;
			out_q[3] <= chain_q[3] + d_q;
		end
	end

	assign digest.valid        = out_valid_q;
	assign digest.digest_word0 = out_q[0];
	assign digest.digest_word1 = out_q[1];
	assign digest.digest_word2 = out_q[2];
	assign digest.digest_word3 = out_q[3];

endmodule

FILE: rtl/md5_stream_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hash unit
// Hashes a byte stream with MD5 and returns one digest per message.
// ----------------------------------------------------------------------------
// The msg channel carries one request per byte: data_byte with has_byte set,
// and last on the final request of a message. A final request may come
// without a byte, which is how an empty message is hashed. The digest
// channel returns the four chaining words, word 0 holding digest bytes 0..3.
// A byte request that does not complete a 64-byte block is taken without
// dropping msg.ready. A request that completes a block holds msg.ready low
// while one shared round unit runs the 64 rounds, one per cycle, with
// the block word read from the buffer memory one round ahead. A last request
// adds padding with cleared buffer words, the length words and a final
// compression, and its digest appears once the digest channel is free;
// the worst case adds a spill block when eight or fewer bytes remain.
// The digest sits in an output register; the unit keeps taking the next
// message while it waits and only stalls before writing a further digest.
// Reset clears the step counter, the byte count and the handshake state and
// loads the MD5 initial chaining values; the block buffer is not cleared,
// since every word is written before it is read.
// ----------------------------------------------------------------------------
module md5_stream_hash_unit (
	input logic         clk,
	input logic         arst_n,
	md5sh_msg_if.sink   msg,
	md5sh_dig_if.source digest
);

	md5sh_pkg::op_t    op;
	md5sh_pkg::flags_t flags;

	// The sequencer walks the control program and picks one operation per
	// cycle; the datapath reports the status bits that the jumps test.
	md5sh_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	md5sh_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.flags  (flags),
		.msg    (msg),
		.digest (digest)
	);

endmodule

FILE: rtl/md5sh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hash: port checker
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module md5sh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] w0,
	input logic [31:0] w1,
	input logic [31:0] w2,
	input logic [31:0] w3
);

	logic fire_last;
	assign fire_last = in_valid & in_ready & in_last;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("digest withdrawn before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(w0) && $stable(w1) && $stable(w2) && $stable(w3))
		else $error("digest changed while stalled");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("digest appeared while requests were being taken");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire_last |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("request taken during message padding");

endmodule

bind md5_stream_hash_unit md5sh_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.in_last   (msg.last),
	.out_valid (digest.valid),
	.out_ready (digest.ready),
	.w0        (digest.digest_word0),
	.w1        (digest.digest_word1),
	.w2        (digest.digest_word2),
	.w3        (digest.digest_word3)
);

FILE: verif/md5_stream_hash_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hash unit testbench
// Streams messages of assorted lengths into the unit one byte per request.
// A scoreboard computes the MD5 digest of each message as its bytes are
// accepted and compares every returned digest with the oldest one waiting.
// ----------------------------------------------------------------------------
module md5_stream_hash_unit_tb;

	// Per-round additive constants and rotation amounts of MD5.
	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int MD5_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	localparam logic [31:0] CHAIN_INIT [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam int REQUEST_TARGET = 1650;
	localparam int MESSAGE_TARGET = 40;
	// Settle well past the longest digest latency plus any output stall.
	localparam int SETTLE_CYCLES = 400;
	localparam int DRAIN_LIMIT = 50000;

	// Word k of a digest sits at [k], so word 0 holds digest bytes 0..3.
	typedef logic [3:0][31:0] digest_words_t;

	// ------------------------------------------------------------------------
	// Scoreboard: a running MD5 of the current message, and the digests of
	// closed messages that the unit has not yet returned, oldest first.
	// ------------------------------------------------------------------------
	class md5_digest_scoreboard;
		logic [31:0] chain [4];
		logic [31:0] block [16];
		logic [60:0] byte_total;
		digest_words_t pending_digests [$];
		int errors;
		int digests_checked;
		int messages_closed;
		int bytes_hashed;

		function new();
			errors = 0;
			digests_checked = 0;
			messages_closed = 0;
			bytes_hashed = 0;
			foreach (block[k])
				block[k] = '0;
			restart();
		endfunction

		function void restart();
			foreach (chain[k])
				chain[k] = CHAIN_INIT[k];
			byte_total = '0;
		endfunction

		function int pending();
			return pending_digests.size();
		endfunction

		// Writes one byte at the current fill position. A write to lane 0
		// clears the rest of the word, and higher lanes keep the lower ones.
		function void place_byte(input logic [7:0] value);
			int w;
			int lane;
			w = int'(byte_total[5:2]);
			lane = int'(byte_total[1:0]);
			block[w] = (block[w] & ((32'd1 << (8 * lane)) - 32'd1))
				| (32'(value) << (8 * lane));
		endfunction

		function void compress();
			logic [31:0] a, b, c, d, f, sum, spin;
			int g;
			int s;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (int i = 0; i < 64; i++) begin
				case (i / 16)
					0: begin
						f = (b & c) | (~b & d);
						g = i;
					end
					1: begin
						f = (b & d) | (c & ~d);
						g = (5 * i + 1) % 16;
					end
					2: begin
						f = b ^ c ^ d;
						g = (3 * i + 5) % 16;
					end
					default: begin
						f = c ^ (b | ~d);
						g = (7 * i) % 16;
					end
				endcase
				s = MD5_S[(i / 16) * 4 + i % 4];
				sum = a + f + MD5_K[i] + block[g];
				spin = (sum << s) | (sum >> (32 - s));
				a = d;
				d = c;
				c = b;
				b = b + spin;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
		endfunction

		// Called once for every accepted request.
		function void note_request(input logic [7:0] value, input logic has_byte,
			input logic last);
			logic [63:0] bit_len;
			digest_words_t digest_expected;
			if (has_byte) begin
				place_byte(value);
				byte_total++;
				bytes_hashed++;
				if (byte_total[5:0] == 6'd0)
					compress();
			end
			if (!last)
				return;
			place_byte(PAD_MARK);
			for (int k = byte_total[5:2] + 1; k < 16; k++)
				block[k] = '0;
			// No room left for the length: it goes into an extra block.
			if (byte_total[5:0] >= 6'd56) begin
				compress();
				foreach (block[k])
					block[k] = '0;
			end
			bit_len = {byte_total, 3'b000};
			block[14] = bit_len[31:0];
			block[15] = bit_len[63:32];
			compress();
			foreach (chain[k])
				digest_expected[k] = chain[k];
			pending_digests = {pending_digests, digest_expected};
			messages_closed++;
			restart();
		endfunction

		function void check_digest(input digest_words_t got);
			digest_words_t want;
			if (pending_digests.size() == 0) begin
				$error("digest returned with no message outstanding: %h", got);
				errors++;
				return;
			end
			want = pending_digests.pop_front();
			digests_checked++;
			for (int k = 0; k < 4; k++) begin
				if (got[k] !== want[k]) begin
					$error("digest_word%0d: expected %h, actual %h", k, want[k], got[k]);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	md5sh_msg_if msg ();
	md5sh_dig_if digest ();

	md5_stream_hash_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (digest)
	);

	md5_digest_scoreboard board = new();

	// When steady is set, neither side inserts any idle cycles. The stimulus
	// switches it on and off so that long back-to-back stretches occur too.
	bit steady = 1'b0;
	int requests_sent = 0;
	int digest_hold = 0;

	always #6 clk = ~clk;

	// Mostly short idle stretches, now and then a long one.
	function automatic int pick_idle(input int longest);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(7, longest);
	endfunction

	// ------------------------------------------------------------------------
	// Digest side. Each accepted digest is checked against the oldest one
	// waiting; ready then drops at random for stalls of varying length.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			digest.ready <= 1'b0;
			digest_hold <= 0;
		end else begin
			if (digest.valid && digest.ready)
				board.check_digest({digest.digest_word3, digest.digest_word2,
					digest.digest_word1, digest.digest_word0});
			if (digest_hold > 0) begin
				digest.ready <= 1'b0;
				digest_hold <= digest_hold - 1;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				digest.ready <= 1'b0;
				digest_hold <= pick_idle(45) - 1;
			end else begin
				digest.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Message side. A request is presented after an optional random gap and
	// held until the unit takes it; it is noted in the scoreboard at the
	// edge where valid and ready are both high. When there is no gap, valid
	// simply stays high into the next request.
	// ------------------------------------------------------------------------
	task automatic send_request(input logic [7:0] value, input logic has_byte,
		input logic last);
		int gap;
		gap = steady ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pick_idle(35));
		if (gap > 0) begin
			// Garbage on the payload while valid is low.
			msg.valid <= 1'b0;
			msg.data_byte <= 8'($urandom_range(0, 255));
			msg.has_byte <= 1'($urandom_range(0, 1));
			msg.last <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
		msg.valid <= 1'b1;
		msg.data_byte <= value;
		msg.has_byte <= has_byte;
		msg.last <= last;
		@(posedge clk);
		while (!msg.ready)
			@(posedge clk);
		board.note_request(value, has_byte, last);
		if (has_byte || last)
			requests_sent++;
	endtask

	// Stops sending until every digest owed has come back.
	task automatic drain_digests();
		int waited;
		msg.valid <= 1'b0;
		for (waited = 0; board.pending() != 0 && waited < DRAIN_LIMIT; waited++)
			@(posedge clk);
	endtask

	// Sends one message of random bytes. The message is closed either by a
	// last flag on its final byte or by a separate request that carries no
	// byte; an empty message always takes the second form. Now and then a
	// request with neither a byte nor last is slipped in, which must be
	// ignored by the unit.
	task automatic send_message(input int length);
		bit separate_close;
		separate_close = (length == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < length; i++) begin
			if ($urandom_range(0, 24) == 0)
				send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_request(8'($urandom_range(0, 255)), 1'b1,
				!separate_close && (i == length - 1));
		end
		if (separate_close)
			send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Message lengths lean toward the padding boundaries: a closing block
	// with room for the length, one that needs an extra block, and lengths
	// that end right at or just past a full block.
	function automatic int pick_length();
		int edges [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		case ($urandom_range(0, 9)) inside
			[0:3]:   return $urandom_range(0, 20);
			[4:6]:   return edges[$urandom_range(0, 11)];
			[7:8]:   return $urandom_range(21, 130);
			default: return $urandom_range(131, 260);
		endcase
	endfunction

	initial begin
		msg.valid = 1'b0;
		msg.data_byte = 8'h00;
		msg.has_byte = 1'b0;
		msg.last = 1'b0;
		digest.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the empty message, a request with neither byte nor
		// last, single-byte messages at both byte extremes, the three-byte
		// text "abc", a message closed by a separate request without a byte
		// after bytes were sent, and two bytes with such an empty request between them.
		send_request(8'h5a, 1'b0, 1'b1);
		send_request(8'ha5, 1'b0, 1'b0);
		send_request(8'h00, 1'b1, 1'b1);
		send_request(8'hff, 1'b1, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'hff, 1'b0, 1'b1);
		send_request(8'h12, 1'b1, 1'b0);
		send_request(8'hc3, 1'b0, 1'b0);
		send_request(8'h34, 1'b1, 1'b1);
		drain_digests();

		// Random messages until enough requests and closed messages have gone by.
		while (requests_sent < REQUEST_TARGET || board.messages_closed < MESSAGE_TARGET) begin
			if ($urandom_range(0, 4) == 0)
				steady = !steady;
			send_message(pick_length());
			if ($urandom_range(0, 7) == 0)
				drain_digests();
		end
		msg.valid <= 1'b0;
		steady = 1'b0;

		drain_digests();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d digests never returned", board.pending());
			board.errors++;
		end

		$display("Hashed %0d messages: %0d bytes in %0d requests, %0d digests checked.",
			board.messages_closed, board.bytes_hashed, requests_sent, board.digests_checked);
		$display("Lengths spanned empty, sub-block, padding-boundary and multi-block cases.");
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#40000000;
		$display("FAILURE");
		$finish;
	end

endmodule
